/* hw/rtl/rtip_pkg.sv */
`timescale 1ns / 1ps

package rtip_pkg;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_BODY0 = 2'd1,
        PH_BODY1 = 2'd2,
        PH_REST  = 2'd3
    } phase_t;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] NOT_A_DIGIT = 6'd63;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // Digit value of a character; letters of either case count from ten.
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                t = c - CH_ZERO;
                return t[5:0];
            end
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                t = c - CH_LOWER_A + LETTER_BASE;
                return t[5:0];
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                t = c - CH_UPPER_A + LETTER_BASE;
                return t[5:0];
            end
            return NOT_A_DIGIT;
        end
    endfunction

endpackage

/* hw/rtl/radix_integer_text_parser_core.sv */
`timescale 1ns / 1ps

// Channel   Signals                               Moves
// -------   -----------------------------------   ------------------------------
// input     in_valid, in_ready, character, last   one character request
// output    out_valid, out_ready, value, ok       one result per string
// config    cfg_we, cfg_wdata                     radix write, no handshake
//
// One character is taken per cycle unless a stalled result holds a last character;
// a string's result passes from the input register through one multiply-add on the
// accumulator into the result register.
// Reset sets the radix to ten and starts a new string; no clearing pass is needed.
// A stalled result holds only a last character in the input register; other
// characters keep flowing into the accumulator.

module radix_integer_text_parser_core
    import rtip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         character,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic               ok
);

    logic [5:0]  radix_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic        s1_advance;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        neg_reg;
    logic        neg_next;
    logic        failed_reg;
    logic        failed_next;
    phase_t      phase_reg;
    phase_t      phase_next;

    logic        out_valid_reg;
    logic signed [31:0] value_reg;
    logic        ok_reg;

    logic [5:0]  digit;
    logic        radix_in_range;
    logic        digit_ok;
    logic        is_sign;
    logic        is_prefix;
    logic        take_digit;
    logic [31:0] product;
    logic        result_ok;

    // A last character may only leave the input register when the result slot frees.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign digit          = digit_value(s1_char_reg);
    assign radix_in_range = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);
    assign digit_ok       = radix_in_range && (digit < radix_reg);
    assign is_sign        = (s1_char_reg == CH_MINUS) || (s1_char_reg == CH_PLUS);
    assign is_prefix      = (radix_reg == RADIX_HEX) && (acc_reg == 32'd0)
                            && ((s1_char_reg == CH_LOWER_X) || (s1_char_reg == CH_UPPER_X));
    assign product        = acc_reg * {26'd0, radix_reg};

    always_comb
    begin
        phase_next = phase_reg;
        if (!failed_reg) begin
            unique case (phase_reg)
                PH_START: phase_next = is_sign ? PH_BODY0 : PH_BODY1;
                PH_BODY0: phase_next = PH_BODY1;
                PH_BODY1: phase_next = PH_REST;
                PH_REST:  phase_next = PH_REST;
                default:  phase_next = PH_START;
            endcase
        end
        if (s1_last_reg) begin
            phase_next = PH_START;
        end
    end

    always_comb
    begin
        take_digit = 1'b0;
        if (!failed_reg) begin
            unique case (phase_reg)
                PH_START: take_digit = !is_sign;
                PH_BODY0: take_digit = 1'b1;
                PH_BODY1: take_digit = !is_prefix;
                PH_REST:  take_digit = 1'b1;
                default:  take_digit = 1'b0;
            endcase
        end
    end

    // The sign is known before any digit, so the accumulator carries the signed
    // value directly: -(a*r + d) equals (-a)*r - d modulo 2^32.
    always_comb
    begin
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        failed_next = failed_reg;
        if (!failed_reg && (phase_reg == PH_START) && (s1_char_reg == CH_MINUS)) begin
            neg_next = 1'b1;
        end
        if (take_digit) begin
            if (digit_ok) begin
                acc_next = neg_reg ? (product - {26'd0, digit})
                                   : (product + {26'd0, digit});
            end else begin
                failed_next = 1'b1;
            end
        end
    end

    assign result_ok = !failed_next && radix_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_we) begin
            radix_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_char_reg <= character;
            s1_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg    <= 32'd0;
            neg_reg    <= 1'b0;
            failed_reg <= 1'b0;
            phase_reg  <= PH_START;
        end else if (s1_advance) begin
            phase_reg <= phase_next;
            if (s1_last_reg) begin
                acc_reg    <= 32'd0;
                neg_reg    <= 1'b0;
                failed_reg <= 1'b0;
            end else begin
                acc_reg    <= acc_next;
                neg_reg    <= neg_next;
                failed_reg <= failed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_advance && s1_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg) begin
            value_reg <= result_ok ? $signed(acc_next) : 32'sd0;
            ok_reg    <= result_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign ok        = ok_reg;

endmodule

/* tb/sv/radix_integer_text_parser_core_tb.sv */
`timescale 1ns / 1ps

module radix_integer_text_parser_core_tb
    import rtip_pkg::*;
;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } char_req_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               good;
    } parse_res_t;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SEND = 2'd1,
        IDLE_RECV = 2'd2,
        IDLE_BOTH = 2'd3
    } idle_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [5:0]         cfg_wdata = RADIX_RESET;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         character = 8'd0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] value;
    logic               ok;

    // Pending character requests and the results they are predicted to give.
    char_req_t  char_q[$];
    parse_res_t parsed_q[$];
    char_req_t  next_req;
    parse_res_t got_res;
    logic [7:0] word_buf[$];

    // Predictor copy of the radix register and the string scan state.
    logic [5:0]  base_reg = RADIX_RESET;
    logic [31:0] acc_reg = 32'd0;
    logic        neg_reg = 1'b0;
    logic        bad_reg = 1'b0;
    phase_t      scan_ph = PH_START;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int str_count = 0;
    int char_count = 0;
    int radix_writes = 0;
    int result_count = 0;

    radix_integer_text_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .ok        (ok)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [5:0] char_digit(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= "0" && c <= "9")
                t = c - 8'h30;
            else if (c >= "a" && c <= "z")
                t = c - 8'h61 + 8'd10;
            else if (c >= "A" && c <= "Z")
                t = c - 8'h41 + 8'd10;
            else
                return NOT_A_DIGIT;
            return t[5:0];
        end
    endfunction

    function automatic logic base_in_range(input logic [5:0] b);
        return (b >= RADIX_MIN) && (b <= RADIX_MAX);
    endfunction

    task automatic take_digit(input logic [7:0] c);
        logic [5:0] d;
        begin
            d = char_digit(c);
            if (!base_in_range(base_reg) || d >= base_reg)
                bad_reg = 1'b1;
            else
                acc_reg = acc_reg * {26'd0, base_reg} + {26'd0, d};
        end
    endtask

    // Advances the scan by one accepted character and queues the result
    // when the character closes its string.
    task automatic parse_char(input logic [7:0] c, input logic lst);
        parse_res_t r;
        begin
            if (!bad_reg)
            begin
                case (scan_ph)
                    PH_START:
                    begin
                        if (c == CH_MINUS)
                        begin
                            neg_reg = 1'b1;
                            scan_ph = PH_BODY0;
                        end
                        else if (c == CH_PLUS)
                            scan_ph = PH_BODY0;
                        else
                        begin
                            take_digit(c);
                            scan_ph = PH_BODY1;
                        end
                    end
                    PH_BODY0:
                    begin
                        take_digit(c);
                        scan_ph = PH_BODY1;
                    end
                    PH_BODY1:
                    begin
                        // A zero accumulator here means the first body character was '0'.
                        if (!(base_reg == RADIX_HEX && acc_reg == 32'd0 &&
                              (c == CH_LOWER_X || c == CH_UPPER_X)))
                            take_digit(c);
                        scan_ph = PH_REST;
                    end
                    default:
                        take_digit(c);
                endcase
            end
            if (lst)
            begin
                if (bad_reg || !base_in_range(base_reg))
                begin
                    r.val = 32'sd0;
                    r.good = 1'b0;
                end
                else
                begin
                    r.val = neg_reg ? $signed(32'd0 - acc_reg) : $signed(acc_reg);
                    r.good = 1'b1;
                end
                parsed_q.push_back(r);
                acc_reg = 32'd0;
                neg_reg = 1'b0;
                bad_reg = 1'b0;
                scan_ph = PH_START;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            character <= 8'd0;
            last <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                parse_char(character, last);
            if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = char_q.pop_front();
                in_valid <= 1'b1;
                character <= next_req.ch;
                last <= next_req.lst;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (parsed_q.size() == 0)
                begin
                    $display("%0t: result with no string pending, expected none, actual value %0d ok %0b",
                             $time, value, ok);
                    err_count++;
                end
                else
                begin
                    got_res = parsed_q.pop_front();
                    if (value !== got_res.val)
                    begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, got_res.val, value);
                        err_count++;
                    end
                    if (ok !== got_res.good)
                    begin
                        $display("%0t: ok mismatch, expected %0b, actual %0b",
                                 $time, got_res.good, ok);
                        err_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_t m);
        begin
            send_idle_pct = (m == IDLE_SEND) ? 48 : (m == IDLE_BOTH) ? 25 : 0;
            recv_stall_pct = (m == IDLE_RECV) ? 48 : (m == IDLE_BOTH) ? 25 : 0;
        end
    endtask

    // Queues the characters gathered in word_buf; close marks the final one as last.
    task automatic send_word(input bit close);
        char_req_t r;
        begin
            for (int i = 0; i < word_buf.size(); i++)
            begin
                r.ch = word_buf[i];
                r.lst = close && (i == word_buf.size() - 1);
                char_q.push_back(r);
            end
            char_count += word_buf.size();
            if (close)
                str_count++;
            word_buf.delete();
        end
    endtask

    task automatic push_text(input string s, input bit close);
        begin
            for (int i = 0; i < s.len(); i++)
                word_buf.push_back(s[i]);
            send_word(close);
        end
    endtask

    task automatic push_byte(input logic [7:0] c);
        begin
            word_buf.push_back(c);
            send_word(1'b1);
        end
    endtask

    // Waits until every request is taken and every result has come, then lets
    // the pipeline settle so that a register write finds the block idle.
    task automatic drain();
        begin
            do
                @(negedge clk);
            while (char_q.size() != 0 || in_valid || parsed_q.size() != 0);
            repeat (8) @(negedge clk);
        end
    endtask

    task automatic set_radix(input logic [5:0] r);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= r;
            @(posedge clk);
            cfg_we <= 1'b0;
            base_reg = r;
            radix_writes++;
        end
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return 8'h30 + d[7:0];
        if ($urandom_range(1) == 0)
            return 8'h61 + d[7:0] - 8'd10;
        return 8'h41 + d[7:0] - 8'd10;
    endfunction

    // Builds one string: mostly well-formed numbers with random digits, some
    // with one character broken, and some pure noise bytes.
    task automatic make_number(input logic [5:0] b);
        int kind;
        int nd;
        int lim;
        int pos;
        bit pre;
        begin
            kind = $urandom_range(99);
            lim = base_in_range(b) ? int'(b) : 10;
            if (kind < 85)
            begin
                pre = 1'b0;
                case ($urandom_range(5))
                    0: word_buf.push_back(CH_MINUS);
                    1: word_buf.push_back(CH_PLUS);
                    default: ;
                endcase
                if (b == RADIX_HEX && $urandom_range(1) == 1)
                begin
                    word_buf.push_back(CH_ZERO);
                    word_buf.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
                    pre = 1'b1;
                end
                nd = ($urandom_range(9) == 0) ? $urandom_range(14, 11) : $urandom_range(9, 1);
                if ((pre || word_buf.size() != 0) && $urandom_range(19) == 0)
                    nd = 0;
                for (int i = 0; i < nd; i++)
                    word_buf.push_back(digit_char($urandom_range(lim - 1)));
                if (kind >= 70)
                begin
                    pos = $urandom_range(word_buf.size() - 1);
                    if (word_buf.size() > 1 && $urandom_range(1) == 1)
                    begin
                        pos = $urandom_range(word_buf.size() - 1, 1);
                        word_buf[pos] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
                    end
                    else
                        word_buf[pos] = 8'($urandom_range(255));
                end
            end
            else
            begin
                nd = $urandom_range(6, 1);
                for (int i = 0; i < nd; i++)
                    word_buf.push_back(8'($urandom_range(255)));
            end
            send_word(1'b1);
        end
    endtask

    initial
    begin
        logic [5:0] good_radix[8];
        logic [5:0] wild_radix[4];
        int chunk_start;

        good_radix = '{6'd2, 6'd8, 6'd10, 6'd16, 6'd36, 6'd16, 6'd10, 6'd0};
        good_radix[7] = 6'($urandom_range(36, 2));
        wild_radix = '{6'd0, 6'd1, 6'd37, 6'd63};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(IDLE_NONE);

        // Reset radix: extremes of the signed range, wrap, lone signs, misplaced signs.
        push_text("2147483647", 1'b1);
        push_text("-2147483648", 1'b1);
        push_text("4294967297", 1'b1);
        push_text("-", 1'b1);
        push_text("+", 1'b1);
        push_text("5-", 1'b1);
        push_text("z9", 1'b1);
        push_text("0x10", 1'b1);
        push_byte(8'h00);
        push_byte(8'hFF);
        drain();

        // Hex prefix handling, including a prefix with nothing after it.
        set_radix(RADIX_HEX);
        push_text("0x", 1'b1);
        push_text("-0X", 1'b1);
        push_text("+0xfF", 1'b1);
        push_text("x", 1'b1);
        push_text("00x1", 1'b1);
        push_text("ffffffff", 1'b1);
        drain();

        set_radix(RADIX_MAX);
        push_text("zZ", 1'b1);
        drain();
        set_radix(RADIX_MIN);
        push_text("101", 1'b1);
        push_text("2", 1'b1);
        drain();

        // The radix changes while a string is open; each character uses the
        // radix that holds when it arrives.
        set_radix(RADIX_RESET);
        push_text("12", 1'b0);
        drain();
        set_radix(RADIX_HEX);
        push_text("a", 1'b1);
        drain();

        for (int k = 0; k < 8; k++)
        begin
            set_radix(good_radix[k]);
            set_idle(idle_mode_t'(k % 4));
            chunk_start = char_count;
            while (char_count - chunk_start < 220)
                make_number(good_radix[k]);
            drain();
        end

        for (int k = 0; k < 4; k++)
        begin
            set_radix(wild_radix[k]);
            set_idle(idle_mode_t'((k + 1) % 4));
            for (int i = 0; i < 3; i++)
                make_number(wild_radix[k]);
            drain();
        end

        $display("Parsed %0d strings (%0d characters, %0d results) over %0d radix writes,",
                 str_count, char_count, result_count, radix_writes);
        $display("in bases 0 to 63 with sender gaps and receiver stalls mixed in.");
        if (err_count == 0)
            $display("radix_integer_text_parser_core_tb: done, clean");
        else
            $display("radix_integer_text_parser_core_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d strings still pending", $time, parsed_q.size());
        $display("radix_integer_text_parser_core_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rtip_pkg.sv
hw/rtl/radix_integer_text_parser_core.sv
tb/sv/radix_integer_text_parser_core_tb.sv
